[rtl/heightmap_box_smoothing_3x3_core_assert.svh]
// Assertion macros shared by the heightmap smoothing RTL.
`ifndef HEIGHTMAP_BOX_SMOOTHING_3X3_CORE_ASSERT_SVH
`define HEIGHTMAP_BOX_SMOOTHING_3X3_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define HBS_ASSERT_NOW(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("hbs assertion failed");

// Next-cycle implication, disabled while reset is high.
`define HBS_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("hbs assertion failed");

`endif

[rtl/hbs_pkg.sv]
// Shared constants, types and helpers of the heightmap smoothing block.
`default_nettype none
package hbs_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MIN_DIM    = 2;

  localparam int HGT_W    = 16;
  localparam int CFG_W    = 11;
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int WID_W    = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W    = $clog2(MAX_HEIGHT + 2);
  localparam int ROWSUM_W = HGT_W + 2;
  localparam int SUM_W    = HGT_W + 4;

  // Division by 4, 6 or 9 as a multiply by a scaled reciprocal.
  localparam int RECIP_W     = 22;
  localparam int RECIP_SHIFT = 23;
  localparam logic [RECIP_W-1:0] RECIP_DIV4 = RECIP_W'(2097152);
  localparam logic [RECIP_W-1:0] RECIP_DIV6 = RECIP_W'(1398102);
  localparam logic [RECIP_W-1:0] RECIP_DIV9 = RECIP_W'(932068);

  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_MAP_WIDTH  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_MAP_HEIGHT = 1'b1;

  typedef logic [HGT_W-1:0] hgt_t;

  // 3x3 neighborhood, indexed [row][column], row 0 on top, column 0 on the left.
  typedef hgt_t [2:0][2:0] win_t;

  typedef struct packed {
    logic emit;
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
    logic last;
  } ctl_t;

  function automatic int unsigned sat_dim(input logic [CFG_W-1:0] raw, input int unsigned hi);
    int unsigned v;
    v = int'(raw);
    if (v < MIN_DIM) v = MIN_DIM;
    if (v > hi) v = hi;
    return v;
  endfunction

endpackage
`default_nettype wire

[rtl/hbs_lines.sv]
// Two line stores holding the previous two rows, read for each item ahead of its update.
`default_nettype none
module hbs_lines import hbs_pkg::*; (
  input  wire logic             clk,
  input  wire logic             adv,
  input  wire logic [COL_W-1:0] rd_addr,
  input  wire logic             wr_en,
  input  wire logic [COL_W-1:0] wr_addr,
  input  wire hgt_t             wr_sample,
  output hgt_t                  up_q,
  output hgt_t                  mid_q
);

  hgt_t upper_mem  [MAX_WIDTH];
  hgt_t middle_mem [MAX_WIDTH];

  // Read data holds while the pipeline is stalled.
  always_ff @(posedge clk) begin
    if (adv) begin
      up_q  <= upper_mem[rd_addr];
      mid_q <= middle_mem[rd_addr];
    end
  end

  // The middle row moves up and the new sample takes its place.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr]  <= mid_q;
      middle_mem[wr_addr] <= wr_sample;
    end
  end

endmodule
`default_nettype wire

[rtl/hbs_mean.sv]
// Masked 3x3 sum and rounded division by the in-bounds cell count.
`default_nettype none
module hbs_mean import hbs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic adv,
  input  wire logic b_valid,
  input  wire ctl_t ctl,
  input  wire win_t win,
  output logic      out_valid,
  output hgt_t      smoothed_height,
  output logic      frame_last
);

  localparam int PROD_W = SUM_W + RECIP_W;

  typedef enum logic [1:0] {
    DIV4,
    DIV6,
    DIV9
  } div_t;

  logic                    c_valid;
  logic                    c_last;
  logic                    c_top_ok;
  logic                    c_bot_ok;
  div_t                    c_div;
  logic [ROWSUM_W-1:0]     c_row [3];
  logic                    d_valid;
  logic                    d_last;
  logic [SUM_W-1:0]        d_x;
  logic [RECIP_W-1:0]      d_m;

  logic [ROWSUM_W-1:0]     row_sum [3];
  div_t                    div_sel;
  logic [SUM_W-1:0]        total;
  logic [SUM_W-1:0]        half;
  logic [RECIP_W-1:0]      recip;
  logic [PROD_W-1:0]       prod;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_sum[r] = (ctl.left_ok ? ROWSUM_W'(win[r][0]) : '0) + ROWSUM_W'(win[r][1])
                 + (ctl.right_ok ? ROWSUM_W'(win[r][2]) : '0);
    end
    if (ctl.top_ok && ctl.bot_ok && ctl.left_ok && ctl.right_ok) begin
      div_sel = DIV9;
    end else if ((ctl.top_ok && ctl.bot_ok) || (ctl.left_ok && ctl.right_ok)) begin
      div_sel = DIV6;
    end else begin
      div_sel = DIV4;
    end
  end

  always_comb begin
    case (c_div)
      DIV9: begin
        half  = SUM_W'(4);
        recip = RECIP_DIV9;
      end
      DIV6: begin
        half  = SUM_W'(3);
        recip = RECIP_DIV6;
      end
      default: begin
        half  = SUM_W'(2);
        recip = RECIP_DIV4;
      end
    endcase
    total = (c_top_ok ? SUM_W'(c_row[0]) : '0) + SUM_W'(c_row[1])
          + (c_bot_ok ? SUM_W'(c_row[2]) : '0) + half;
  end

  assign prod = PROD_W'(d_x) * PROD_W'(d_m);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      c_valid   <= b_valid && ctl.emit;
      d_valid   <= c_valid;
      out_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_row           <= row_sum;
      c_top_ok        <= ctl.top_ok;
      c_bot_ok        <= ctl.bot_ok;
      c_div           <= div_sel;
      c_last          <= ctl.last;
      d_x             <= total;
      d_m             <= recip;
      d_last          <= c_last;
      smoothed_height <= prod[RECIP_SHIFT +: HGT_W];
      frame_last      <= d_last;
    end
  end

endmodule
`default_nettype wire

[rtl/heightmap_box_smoothing_3x3_core.sv]
// Top level of the streaming 3x3 heightmap smoothing filter.
`default_nettype none
`include "heightmap_box_smoothing_3x3_core_assert.svh"
// Takes one item per cycle unless in_stall is high: a height sample in raster order or a flush
// tick. Each result is the rounded mean of the in-bounds cells around one map position and trails
// its inputs by one row plus one sample; after the last sample of a frame, map_width + 1 flush
// ticks drain the rest. Flush ticks that arrive before the frame is complete are taken and dropped.
// A result is presented through four register stages: line store read, window and row sums,
// total and reciprocal select, multiply. The two line stores are read when an item is taken and
// written when that item moves on from its first register stage; consecutive items always touch
// different columns, so no forwarding is needed, and the stores need no clearing pass since their
// stale cells are always out of bounds. The whole pipeline holds while a result waits on a stalled
// output. A configuration write restarts the frame.
module heightmap_box_smoothing_3x3_core import hbs_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [REG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 action,
  input  wire logic [HGT_W-1:0]     height_sample,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [HGT_W-1:0]          smoothed_height,
  output logic                      frame_last
);

  logic [WID_W-1:0] eff_w;
  logic [ROW_W-1:0] eff_h;
  logic [COL_W-1:0] col_cnt;
  logic [ROW_W-1:0] row_cnt;
  logic [COL_W-1:0] col_cnt_next;
  logic [ROW_W-1:0] row_cnt_next;

  logic             b_valid;
  logic             b_flush;
  logic [COL_W-1:0] b_col;
  hgt_t             b_bot;
  ctl_t             b_ctl;

  hgt_t             win_l [3];
  hgt_t             win_c [3];
  hgt_t             up_q;
  hgt_t             mid_q;
  win_t             win;

  logic             adv;
  logic             acc;
  logic             live;
  logic             flush;
  logic             col_zero;
  ctl_t             a_ctl;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;
  assign acc      = in_valid && adv;

  always_comb begin
    flush    = action || (row_cnt >= eff_h);
    // A flush tick inside the frame is taken and has no effect.
    live     = acc && !(action && (row_cnt < eff_h));
    col_zero = (col_cnt == '0);

    // At column zero the result is the last position of the row two above.
    a_ctl.emit     = col_zero ? (row_cnt >= ROW_W'(2)) : (row_cnt >= ROW_W'(1));
    a_ctl.top_ok   = col_zero ? (row_cnt != ROW_W'(2)) : (row_cnt != ROW_W'(1));
    a_ctl.bot_ok   = col_zero ? (row_cnt <= eff_h) : (row_cnt < eff_h);
    a_ctl.left_ok  = col_zero || (col_cnt != COL_W'(1));
    a_ctl.right_ok = !col_zero;
    a_ctl.last     = col_zero && (row_cnt == eff_h + ROW_W'(1));

    if (a_ctl.last) begin
      col_cnt_next = '0;
      row_cnt_next = '0;
    end else if (WID_W'(col_cnt) + WID_W'(1) == eff_w) begin
      col_cnt_next = '0;
      row_cnt_next = row_cnt + ROW_W'(1);
    end else begin
      col_cnt_next = col_cnt + COL_W'(1);
      row_cnt_next = row_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_w   <= WID_W'(MAX_WIDTH);
      eff_h   <= ROW_W'(MAX_HEIGHT);
      col_cnt <= '0;
      row_cnt <= '0;
      b_valid <= 1'b0;
    end else begin
      if (adv) begin
        b_valid <= live;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          REG_MAP_WIDTH:  eff_w <= WID_W'(sat_dim(cfg_data, MAX_WIDTH));
          REG_MAP_HEIGHT: eff_h <= ROW_W'(sat_dim(cfg_data, MAX_HEIGHT));
          default: begin
          end
        endcase
        col_cnt <= '0;
        row_cnt <= '0;
      end else if (live) begin
        col_cnt <= col_cnt_next;
        row_cnt <= row_cnt_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_flush <= flush;
      b_col   <= col_cnt;
      b_bot   <= flush ? '0 : height_sample;
      b_ctl   <= a_ctl;
    end
    if (adv && b_valid) begin
      for (int r = 0; r < 3; r++) begin
        win_l[r] <= win_c[r];
      end
      win_c[0] <= up_q;
      win_c[1] <= mid_q;
      win_c[2] <= b_bot;
    end
  end

  hbs_lines u_lines (
    .clk       (clk),
    .adv       (adv),
    .rd_addr   (col_cnt),
    .wr_en     (adv && b_valid && !b_flush),
    .wr_addr   (b_col),
    .wr_sample (b_bot),
    .up_q      (up_q),
    .mid_q     (mid_q)
  );

  // Left and center come from the window, right is the column being read in.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win_l[r];
      win[r][1] = win_c[r];
    end
    win[0][2] = up_q;
    win[1][2] = mid_q;
    win[2][2] = b_bot;
  end

  hbs_mean u_mean (
    .clk             (clk),
    .rst             (rst),
    .adv             (adv),
    .b_valid         (b_valid),
    .ctl             (b_ctl),
    .win             (win),
    .out_valid       (out_valid),
    .smoothed_height (smoothed_height),
    .frame_last      (frame_last)
  );

  `HBS_ASSERT_NOW(a_col_in_row, clk, rst, 1'b1, WID_W'(col_cnt) < eff_w)
  `HBS_ASSERT_NOW(a_row_bound, clk, rst, 1'b1, row_cnt <= eff_h + ROW_W'(1))
  `HBS_ASSERT_NEXT(a_last_restarts, clk, rst, live && a_ctl.last, (col_cnt == '0) && (row_cnt == '0))

endmodule
`default_nettype wire
